### src/vtdc_pkg.sv
// ----------------------------------------------------------------------------
// vtdc_pkg
// Shared types, register codes and reset values for the voted trigger
// debounce block.
// ----------------------------------------------------------------------------
package vtdc_pkg;

    // Default number of samples of each trigger line in one poll.
    localparam int VOTE_SAMPLES_DEF = 5;

    localparam int TIME_W    = 32;
    localparam int MS_W      = 16;
    localparam int COUNT_W   = 8;
    localparam int THR_W     = 3;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [COUNT_W-1:0] CONFIRM_RST  = 8'd8;
    localparam logic [MS_W-1:0]    SPACING_RST  = 16'd10;
    localparam logic [MS_W-1:0]    COOLDOWN_RST = 16'd1000;
    localparam logic [THR_W-1:0]   THRESH_RST   = 3'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONFIRM_COUNT = 8'd0,
        CFG_SPACING_MS    = 8'd1,
        CFG_COOLDOWN_MS   = 8'd2,
        CFG_THRESHOLD     = 8'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DEB  = 2'd1,
        PH_TRIG = 2'd2,
        PH_COOL = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_FIRST  = 2'd1,
        MODE_SECOND = 2'd2
    } mode_t;

    typedef struct packed {
        logic [COUNT_W-1:0] confirm_count;
        logic [MS_W-1:0]    sample_spacing_ms;
        logic [MS_W-1:0]    cooldown_ms;
        logic [THR_W-1:0]   vote_threshold;
    } vtdc_cfg_t;

    typedef struct packed {
        logic   fire;
        logic   fire_mode;
        phase_t phase;
        mode_t  voted_mode;
    } vtdc_result_t;

endpackage

### src/vtdc_if.sv
// ----------------------------------------------------------------------------
// vtdc_if
// Valid/ready channels of the voted trigger debounce block: poll words in,
// result words out, and the register write channel.
// ----------------------------------------------------------------------------
interface vtdc_poll_if #(
    parameter int SAMPLES = vtdc_pkg::VOTE_SAMPLES_DEF
);
    logic                        valid;
    logic                        ready;
    logic [vtdc_pkg::TIME_W-1:0] now_ms;
    logic [SAMPLES-1:0]          first_line_samples;
    logic [SAMPLES-1:0]          second_line_samples;

    modport source (
        output valid, now_ms, first_line_samples, second_line_samples,
        input  ready
    );
    modport sink (
        input  valid, now_ms, first_line_samples, second_line_samples,
        output ready
    );
endinterface

interface vtdc_result_if;
    logic       valid;
    logic       ready;
    logic       fire;
    logic       fire_mode;
    logic [1:0] phase;
    logic [1:0] voted_mode;

    modport source (
        output valid, fire, fire_mode, phase, voted_mode,
        input  ready
    );
    modport sink (
        input  valid, fire, fire_mode, phase, voted_mode,
        output ready
    );
endinterface

interface vtdc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [vtdc_pkg::CFG_IDX_W-1:0] index;
    logic [vtdc_pkg::CFG_DAT_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### src/vtdc_vote.sv
// ----------------------------------------------------------------------------
// vtdc_vote
// Majority vote of one poll: counts the set samples of each line and picks
// the mode, the first line taking priority.
// ----------------------------------------------------------------------------
module vtdc_vote #(
    parameter int VOTE_SAMPLES = vtdc_pkg::VOTE_SAMPLES_DEF
) (
    input  logic [VOTE_SAMPLES-1:0]      first_line_samples,
    input  logic [VOTE_SAMPLES-1:0]      second_line_samples,
    input  logic [vtdc_pkg::THR_W-1:0]   vote_threshold,
    output vtdc_pkg::mode_t              vote
);

    localparam int CNT_W = $clog2(VOTE_SAMPLES + 1);
    localparam int CMP_W = (CNT_W > vtdc_pkg::THR_W) ? CNT_W : vtdc_pkg::THR_W;

    function automatic logic [CNT_W-1:0] count_set(input logic [VOTE_SAMPLES-1:0] bits);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < VOTE_SAMPLES; i++)
        begin
            n = n + CNT_W'(bits[i]);
        end
        return n;
    endfunction

    logic [CMP_W-1:0] first_cnt;
    logic [CMP_W-1:0] second_cnt;
    logic [CMP_W-1:0] thresh;

    assign first_cnt  = CMP_W'(count_set(first_line_samples));
    assign second_cnt = CMP_W'(count_set(second_line_samples));
    assign thresh     = CMP_W'(vote_threshold);

    always_comb
    begin
        if (first_cnt >= thresh)
        begin
            vote = vtdc_pkg::MODE_FIRST;
        end
        else if (second_cnt >= thresh)
        begin
            vote = vtdc_pkg::MODE_SECOND;
        end
        else
        begin
            vote = vtdc_pkg::MODE_NONE;
        end
    end

endmodule

### src/vtdc_fsm.sv
// ----------------------------------------------------------------------------
// vtdc_fsm
// Four-phase debounce machine: confirms a voted mode over spaced polls,
// pulses fire, waits for release and holds off for the cooldown time.
// ----------------------------------------------------------------------------
module vtdc_fsm (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [vtdc_pkg::TIME_W-1:0] now_ms,
    input  vtdc_pkg::mode_t             vote,
    input  vtdc_pkg::vtdc_cfg_t         cfg,
    output vtdc_pkg::vtdc_result_t      result
);

    vtdc_pkg::phase_t                 phase_reg, phase_next;
    logic [vtdc_pkg::TIME_W-1:0]      start_reg, start_next;
    logic [vtdc_pkg::COUNT_W-1:0]     count_reg, count_next;
    vtdc_pkg::mode_t                  latched_reg, latched_next;

    logic [vtdc_pkg::TIME_W-1:0]      elapsed;
    logic                             spacing_ok;
    logic                             cool_ok;
    logic                             match;
    logic [vtdc_pkg::COUNT_W-1:0]     count_inc;
    logic                             confirmed;

    // Time differences wrap modulo 2^32.
    assign elapsed    = now_ms - start_reg;
    assign spacing_ok = elapsed >= vtdc_pkg::TIME_W'(cfg.sample_spacing_ms);
    assign cool_ok    = elapsed >= vtdc_pkg::TIME_W'(cfg.cooldown_ms);
    assign match      = (vote == latched_reg);
    assign count_inc  = (count_reg == vtdc_pkg::COUNT_MAX) ? count_reg
                                                          : count_reg + 8'd1;
    assign confirmed  = count_inc >= cfg.confirm_count;

    always_comb
    begin
        phase_next   = phase_reg;
        start_next   = start_reg;
        count_next   = count_reg;
        latched_next = latched_reg;
        case (phase_reg)
            vtdc_pkg::PH_IDLE:
            begin
                if (vote != vtdc_pkg::MODE_NONE)
                begin
                    phase_next   = vtdc_pkg::PH_DEB;
                    start_next   = now_ms;
                    count_next   = 8'd1;
                    latched_next = vote;
                end
            end
            vtdc_pkg::PH_DEB:
            begin
                if (spacing_ok)
                begin
                    if (match)
                    begin
                        count_next = count_inc;
                        start_next = now_ms;
                        if (confirmed)
                        begin
                            phase_next = vtdc_pkg::PH_TRIG;
                        end
                    end
                    else
                    begin
                        phase_next   = vtdc_pkg::PH_IDLE;
                        count_next   = '0;
                        latched_next = vtdc_pkg::MODE_NONE;
                    end
                end
            end
            vtdc_pkg::PH_TRIG:
            begin
                if (vote == vtdc_pkg::MODE_NONE)
                begin
                    phase_next = vtdc_pkg::PH_COOL;
                    start_next = now_ms;
                end
            end
            vtdc_pkg::PH_COOL:
            begin
                if (cool_ok)
                begin
                    phase_next   = vtdc_pkg::PH_IDLE;
                    latched_next = vtdc_pkg::MODE_NONE;
                end
            end
            default:
            begin
                phase_next = vtdc_pkg::PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result.fire       = (phase_reg == vtdc_pkg::PH_DEB) && spacing_ok && match
                            && confirmed;
        result.fire_mode  = result.fire && (latched_reg == vtdc_pkg::MODE_SECOND);
        result.phase      = phase_next;
        result.voted_mode = vote;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= vtdc_pkg::PH_IDLE;
            start_reg   <= '0;
            count_reg   <= '0;
            latched_reg <= vtdc_pkg::MODE_NONE;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            start_reg   <= start_next;
            count_reg   <= count_next;
            latched_reg <= latched_next;
        end
    end

endmodule

### src/voted_trigger_debounce_cooldown.sv
// ----------------------------------------------------------------------------
// voted_trigger_debounce_cooldown
// Debounces two voted trigger lines and pulses fire once per confirmed press.
// ----------------------------------------------------------------------------
// Usage:
// Each poll word on the poll channel carries a millisecond timestamp and the
// samples of both trigger lines. For every poll exactly one word leaves on
// the result channel: fire, fire_mode, the phase after the poll and the vote.
// A poll is captured in an input register; the vote and the phase update are
// computed from it and land in the result register, which makes the word
// valid, when the poll moves on; the phase state is updated at that point.
// One poll is taken every cycle while the receiver keeps taking results.
// When the receiver stalls, the result register holds and the input register
// still takes one more poll; after that the poll channel drops ready.
// Reset clears the phase machine to idle and restores the register defaults:
// confirm count 8, spacing 10 ms, cooldown 1000 ms, threshold 3.
// The register channel is always ready and should be written only while no
// poll is in flight. The poll interface must be built with SAMPLES equal to
// VOTE_SAMPLES.
// ----------------------------------------------------------------------------
module voted_trigger_debounce_cooldown #(
    parameter int VOTE_SAMPLES = vtdc_pkg::VOTE_SAMPLES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    vtdc_poll_if.sink     poll,
    vtdc_result_if.source result,
    vtdc_cfg_if.sink      cfg
);

    vtdc_pkg::vtdc_cfg_t          cfg_reg;

    logic                         in_valid_reg;
    logic [vtdc_pkg::TIME_W-1:0]  now_reg;
    logic [VOTE_SAMPLES-1:0]      first_reg;
    logic [VOTE_SAMPLES-1:0]      second_reg;

    logic                         out_valid_reg;
    vtdc_pkg::vtdc_result_t       out_reg;

    logic                         advance;
    vtdc_pkg::mode_t              vote;
    vtdc_pkg::vtdc_result_t       res_next;

    // Register writes.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.confirm_count     <= vtdc_pkg::CONFIRM_RST;
            cfg_reg.sample_spacing_ms <= vtdc_pkg::SPACING_RST;
            cfg_reg.cooldown_ms       <= vtdc_pkg::COOLDOWN_RST;
            cfg_reg.vote_threshold    <= vtdc_pkg::THRESH_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                vtdc_pkg::CFG_CONFIRM_COUNT:
                    cfg_reg.confirm_count <= cfg.data[vtdc_pkg::COUNT_W-1:0];
                vtdc_pkg::CFG_SPACING_MS:
                    cfg_reg.sample_spacing_ms <= cfg.data[vtdc_pkg::MS_W-1:0];
                vtdc_pkg::CFG_COOLDOWN_MS:
                    cfg_reg.cooldown_ms <= cfg.data[vtdc_pkg::MS_W-1:0];
                vtdc_pkg::CFG_THRESHOLD:
                    cfg_reg.vote_threshold <= cfg.data[vtdc_pkg::THR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // The held poll moves on whenever the result register is free or drains.
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign poll.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (poll.ready)
        begin
            in_valid_reg <= poll.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll.ready && poll.valid)
        begin
            now_reg    <= poll.now_ms;
            first_reg  <= poll.first_line_samples;
            second_reg <= poll.second_line_samples;
        end
    end

    vtdc_vote #(
        .VOTE_SAMPLES(VOTE_SAMPLES)
    ) u_vote (
        .first_line_samples (first_reg),
        .second_line_samples(second_reg),
        .vote_threshold     (cfg_reg.vote_threshold),
        .vote               (vote)
    );

    vtdc_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .now_ms(now_reg),
        .vote  (vote),
        .cfg   (cfg_reg),
        .result(res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= res_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.fire       = out_reg.fire;
    assign result.fire_mode  = out_reg.fire_mode;
    assign result.phase      = out_reg.phase;
    assign result.voted_mode = out_reg.voted_mode;

endmodule

### verif/vtdc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtdc_checker
// Watches the poll, result and register channels of the voted trigger
// debounce block, predicts one result word per accepted poll and compares
// every returned word field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module vtdc_checker
    import vtdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    vtdc_poll_if        poll,
    vtdc_result_if      result,
    vtdc_cfg_if         cfg,
    output int unsigned errors,
    output int unsigned pending
);

    // Shadow of the register file.
    logic [COUNT_W-1:0] confirm_cnt;
    logic [MS_W-1:0]    spacing_ms;
    logic [MS_W-1:0]    hold_off_ms;
    logic [THR_W-1:0]   threshold;

    // Shadow of the phase machine.
    phase_t             phase;
    logic [TIME_W-1:0]  phase_start;
    logic [COUNT_W-1:0] run_len;
    mode_t              latched;

    vtdc_result_t       expected_words[$];

    task automatic check_field(input string name, input logic [1:0] want,
                               input logic [1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        mode_t             vote;
        logic [TIME_W-1:0] elapsed;
        vtdc_result_t      want;
        if (!rst_n)
        begin
            confirm_cnt = CONFIRM_RST;
            spacing_ms  = SPACING_RST;
            hold_off_ms = COOLDOWN_RST;
            threshold   = THRESH_RST;
            phase       = PH_IDLE;
            phase_start = '0;
            run_len     = '0;
            latched     = MODE_NONE;
            expected_words.delete();
            errors      = 0;
            pending     = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_CONFIRM_COUNT: confirm_cnt = cfg.data[COUNT_W-1:0];
                    CFG_SPACING_MS:    spacing_ms  = cfg.data[MS_W-1:0];
                    CFG_COOLDOWN_MS:   hold_off_ms = cfg.data[MS_W-1:0];
                    CFG_THRESHOLD:     threshold   = cfg.data[THR_W-1:0];
                    default: ;
                endcase
            end

            if (poll.valid && poll.ready)
            begin
                // The first line wins whenever both lines vote active.
                if ($countones(poll.first_line_samples) >= threshold)
                    vote = MODE_FIRST;
                else if ($countones(poll.second_line_samples) >= threshold)
                    vote = MODE_SECOND;
                else
                    vote = MODE_NONE;

                elapsed = poll.now_ms - phase_start;
                want = '0;
                want.voted_mode = vote;

                case (phase)
                    PH_IDLE:
                    begin
                        if (vote != MODE_NONE)
                        begin
                            phase       = PH_DEB;
                            phase_start = poll.now_ms;
                            run_len     = 8'd1;
                            latched     = vote;
                        end
                    end
                    PH_DEB:
                    begin
                        // Polls that come before the spacing has passed are ignored.
                        if (elapsed >= 32'(spacing_ms))
                        begin
                            if (vote == latched)
                            begin
                                if (run_len != COUNT_MAX)
                                    run_len = run_len + 8'd1;
                                phase_start = poll.now_ms;
                                if (run_len >= confirm_cnt)
                                begin
                                    want.fire      = 1'b1;
                                    want.fire_mode = (latched == MODE_SECOND);
                                    phase          = PH_TRIG;
                                end
                            end
                            else
                            begin
                                phase   = PH_IDLE;
                                run_len = '0;
                                latched = MODE_NONE;
                            end
                        end
                    end
                    PH_TRIG:
                    begin
                        if (vote == MODE_NONE)
                        begin
                            phase       = PH_COOL;
                            phase_start = poll.now_ms;
                        end
                    end
                    default:
                    begin
                        if (elapsed >= 32'(hold_off_ms))
                        begin
                            phase   = PH_IDLE;
                            latched = MODE_NONE;
                        end
                    end
                endcase

                want.phase = phase;
                expected_words.push_back(want);
            end

            if (result.valid && result.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with no poll outstanding: fire %0d phase %0d vote %0d",
                           result.fire, result.phase, result.voted_mode);
                    errors++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("fire", 2'(want.fire), 2'(result.fire));
                    check_field("fire_mode", 2'(want.fire_mode), 2'(result.fire_mode));
                    check_field("phase", want.phase, result.phase);
                    check_field("voted_mode", want.voted_mode, result.voted_mode);
                end
            end

            pending = expected_words.size();
        end
    end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives polls and register writes into the voted trigger debounce block:
// a short directed walk through every phase, then press sequences, broken
// presses and noise under several register settings, with random stalls on
// both channels. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import vtdc_pkg::*;

    localparam int unsigned           CYCLE_LIMIT  = 600000;
    localparam int unsigned           HOLD_AFTER   = 150;
    localparam int unsigned           HOLD_CYCLES  = 120;
    localparam logic [CFG_IDX_W-1:0]  CFG_UNMAPPED = 8'd200;

    logic               clk;
    logic               rst_n;
    int unsigned        mismatches;
    int unsigned        pending;
    int unsigned        polls_sent;
    int unsigned        cyc_count;
    bit                 calm;
    logic [TIME_W-1:0]  ms_now;

    // Register values as last written, used to shape the stimulus.
    logic [COUNT_W-1:0] cur_confirm;
    logic [MS_W-1:0]    cur_spacing;
    logic [MS_W-1:0]    cur_cooldown;
    logic [THR_W-1:0]   cur_thr;

    vtdc_poll_if #(.SAMPLES(VOTE_SAMPLES_DEF)) poll_ch ();
    vtdc_result_if res_ch ();
    vtdc_cfg_if    cfg_ch ();

    voted_trigger_debounce_cooldown #(
        .VOTE_SAMPLES(VOTE_SAMPLES_DEF)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .poll   (poll_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    vtdc_checker watch (
        .clk     (clk),
        .rst_n   (rst_n),
        .poll    (poll_ch),
        .result  (res_ch),
        .cfg     (cfg_ch),
        .errors  (mismatches),
        .pending (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cyc_count <= cyc_count + 1;
        if (cyc_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [4:0] samples_for(input bit active);
        logic [4:0]  v;
        int unsigned tries;
        v = 5'($urandom_range(0, 31));
        if (cur_thr == 0 || cur_thr > VOTE_SAMPLES_DEF)
            return v;
        for (tries = 0; tries < 64; tries++)
        begin
            if (($countones(v) >= cur_thr) == active)
                return v;
            v = 5'($urandom_range(0, 31));
        end
        return active ? 5'h1F : 5'h00;
    endfunction

    function automatic logic [TIME_W-1:0] spaced_delta();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 32'(cur_spacing) + $urandom_range(0, 3);
        if (r < 88)
            return $urandom_range(0, 32'(cur_spacing));
        return $urandom_range(0, 3 * 32'(cur_spacing) + 5);
    endfunction

    function automatic logic [TIME_W-1:0] noise_delta();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(0, 2 * 32'(cur_spacing) + 2);
        if (r < 80)
            return $urandom_range(0, 32'(cur_cooldown) + 32'(cur_spacing) + 1);
        return $urandom();
    endfunction

    task automatic send_poll(input logic [4:0] first, input logic [4:0] second);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            poll_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        poll_ch.valid               <= 1'b1;
        poll_ch.now_ms              <= ms_now;
        poll_ch.first_line_samples  <= first;
        poll_ch.second_line_samples <= second;
        do @(posedge clk); while (!poll_ch.ready);
        polls_sent++;
    endtask

    task automatic poll_vote(input mode_t m);
        case (m)
            MODE_FIRST:  send_poll(samples_for(1'b1), 5'($urandom_range(0, 31)));
            MODE_SECOND: send_poll(samples_for(1'b0), samples_for(1'b1));
            default:     send_poll(samples_for(1'b0), samples_for(1'b0));
        endcase
    endtask

    task automatic noise(input int unsigned n);
        repeat (n)
        begin
            ms_now += noise_delta();
            send_poll(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
        end
    endtask

    // One press: enter, count spaced polls up to confirmation, hold, release,
    // then polls through the cooldown. A broken press votes differently
    // part way through the count.
    task automatic press(input mode_t m, input bit broken);
        int unsigned       need, counted, steps, cut;
        logic [TIME_W-1:0] d, since;
        need    = (cur_confirm < 2) ? 2 : 32'(cur_confirm);
        cut     = broken ? $urandom_range(1, need) : 0;
        counted = 1;
        steps   = 0;
        since   = '0;
        ms_now += $urandom_range(0, 40);
        poll_vote(m);
        while (counted < need && steps < 2 * need + 4)
        begin
            steps++;
            d = spaced_delta();
            ms_now += d;
            since  += d;
            if (steps == cut)
            begin
                poll_vote((m == MODE_FIRST) ? MODE_SECOND : MODE_NONE);
                return;
            end
            if (since >= 32'(cur_spacing))
            begin
                counted++;
                since = '0;
            end
            poll_vote(m);
        end
        repeat ($urandom_range(0, 3))
        begin
            ms_now += $urandom_range(0, 50);
            poll_vote(m);
        end
        ms_now += $urandom_range(0, 50);
        poll_vote(MODE_NONE);
        repeat ($urandom_range(1, 4))
        begin
            ms_now += $urandom_range(0, 32'(cur_cooldown) / 2 + 10);
            poll_vote(mode_t'($urandom_range(0, 2)));
        end
        if ($urandom_range(0, 1) == 1)
            ms_now += 32'(cur_cooldown);
    endtask

    // Stop offering polls and wait until every result word has come back.
    task automatic drain();
        poll_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input int unsigned budget);
        int unsigned stop_at, pick;
        stop_at = polls_sent + budget;
        while (polls_sent < stop_at)
        begin
            calm = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 6)
                press(mode_t'($urandom_range(1, 2)), 1'b0);
            else if (pick < 8)
                press(mode_t'($urandom_range(1, 2)), 1'b1);
            else
                noise($urandom_range(1, 6));
        end
        calm = 1'b0;
        drain();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_CONFIRM_COUNT: cur_confirm  = val[COUNT_W-1:0];
            CFG_SPACING_MS:    cur_spacing  = val[MS_W-1:0];
            CFG_COOLDOWN_MS:   cur_cooldown = val[MS_W-1:0];
            CFG_THRESHOLD:     cur_thr      = val[THR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [CFG_DAT_W-1:0] confirm,
                           input logic [CFG_DAT_W-1:0] spacing,
                           input logic [CFG_DAT_W-1:0] cooldown,
                           input logic [CFG_DAT_W-1:0] thr);
        write_reg(CFG_CONFIRM_COUNT, confirm);
        write_reg(CFG_SPACING_MS, spacing);
        write_reg(CFG_COOLDOWN_MS, cooldown);
        write_reg(CFG_THRESHOLD, thr);
    endtask

    // Result side: random stalls, and one long hold-off while polls keep
    // coming so that the block fills up and drops ready on the poll side.
    initial
    begin : receiver
        int unsigned seen;
        int unsigned stall_left;
        bit          held;
        seen       = 0;
        stall_left = 0;
        held       = 1'b0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
                seen++;
            if (!held && seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                stall_left = pick_gap();
                res_ch.ready <= (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned k;
        rst_n      = 1'b0;
        calm       = 1'b0;
        polls_sent = 0;
        ms_now     = '0;
        poll_ch.valid               = 1'b0;
        poll_ch.now_ms              = '0;
        poll_ch.first_line_samples  = '0;
        poll_ch.second_line_samples = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        cur_confirm  = CONFIRM_RST;
        cur_spacing  = SPACING_RST;
        cur_cooldown = COOLDOWN_RST;
        cur_thr      = THRESH_RST;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk with the reset settings. The first press starts at
        // the top of the time range, so its first counted poll wraps.
        ms_now = 32'h0000_0000;
        send_poll(5'h00, 5'h00);
        ms_now = 32'hFFFF_FFFF;
        send_poll(5'h1F, 5'h1F);
        send_poll(5'h1F, 5'h00);
        for (k = 0; k < 7; k++)
        begin
            ms_now += 32'd10;
            send_poll(5'b00111, 5'h00);
        end
        ms_now += 32'd3;
        send_poll(5'b11100, 5'h00);
        ms_now += 32'd1;
        send_poll(5'b00011, 5'b11000);
        ms_now += 32'd999;
        send_poll(5'h1F, 5'h00);
        ms_now += 32'd1;
        send_poll(5'h00, 5'h00);
        ms_now += 32'd5;
        send_poll(5'h00, 5'b10101);
        for (k = 0; k < 7; k++)
        begin
            ms_now += 32'd11;
            send_poll(5'b00011, 5'b01110);
        end
        ms_now += 32'd2;
        send_poll(5'b10000, 5'b00001);
        drain();

        run_phase(40);

        // Fastest settings: confirmation on the first counted poll.
        set_all(16'd1, 16'd0, 16'd0, 16'd1);
        ms_now = 32'hFFFF_FF80;
        run_phase(50);

        // Confirm count zero and threshold zero, upper data bits set.
        set_all(16'hAB00, 16'd3, 16'd40, 16'hFFF8);
        ms_now = $urandom();
        run_phase(40);

        // Slowest settings: one full press at the largest count and spacing.
        set_all(16'h12FF, 16'hFFFF, 16'hFFFF, 16'd5);
        ms_now = $urandom();
        press(MODE_SECOND, 1'b0);
        noise(6);
        drain();

        // A threshold above the sample count never votes.
        set_all(16'd4, 16'd7, 16'd100, 16'h000F);
        noise(15);
        drain();
        write_reg(CFG_UNMAPPED, 16'hFFFF);

        repeat (2)
        begin
            set_all({8'($urandom()), 8'($urandom_range(1, 6))},
                    16'($urandom_range(0, 30)),
                    16'($urandom_range(0, 300)),
                    {13'($urandom()), 3'($urandom_range(1, 5))});
            ms_now = $urandom();
            run_phase(50);
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### sim.f
src/vtdc_pkg.sv
src/vtdc_if.sv
src/vtdc_vote.sv
src/vtdc_fsm.sv
src/voted_trigger_debounce_cooldown.sv
verif/vtdc_checker.sv
verif/tb.sv
